### hw/rtl/bbsf_pkg.sv
// Package for the bounded byte stream FIFO core.
// Holds store geometry, field widths, request codes and controller command type.
// No dependencies.
package bbsf_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = ADDR_W + 1;
   localparam int CAP_W   = 11;
   localparam int LEN_W   = 16;
   localparam int TOTAL_W = 32;
   localparam int WIDE_W  = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
   localparam int CMP_W   = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);

   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   typedef struct packed {
      logic load;   // capture the request word
      logic exec;   // apply the request to the FIFO state
      logic read;   // fetch the front byte from the store
   } cmd_type;

endpackage

### hw/rtl/bbsf_ctrl.sv
// Controller state machine for the bounded byte stream FIFO core.
// Sequences load, execute, store read and response; uses bbsf_pkg.
module bbsf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbsf_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = req_valid && (state_ff == ST_IDLE);
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign cmd.read  = (state_ff == ST_READ);

endmodule

### hw/rtl/bbsf_datapath.sv
// Datapath of the bounded byte stream FIFO core: byte store, pointers,
// totals, flags and capacity register. Uses bbsf_pkg.
module bbsf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bbsf_pkg::cmd_type              cmd,
   input  logic                           csr_write_enable,
   input  logic [bbsf_pkg::CAP_W-1:0]     csr_write_data,
   input  logic [1:0]                     req_type,
   input  logic [7:0]                     req_push_byte,
   input  logic [bbsf_pkg::LEN_W-1:0]     req_pop_len,
   output logic [7:0]                     rsp_front_byte,
   output logic                           rsp_front_valid,
   output logic [10:0]                    rsp_buffered_count,
   output logic [10:0]                    rsp_free_count,
   output logic [bbsf_pkg::TOTAL_W-1:0]   rsp_pushed_count,
   output logic [bbsf_pkg::TOTAL_W-1:0]   rsp_popped_count,
   output logic                           rsp_closed_flag,
   output logic                           rsp_finished_flag,
   output logic                           rsp_error_flag
);

   logic [7:0]                     mem [bbsf_pkg::DEPTH];
   logic [7:0]                     rd_data_ff;

   logic [1:0]                     type_ff;
   logic [7:0]                     byte_ff;
   logic [bbsf_pkg::LEN_W-1:0]     len_ff;

   logic [bbsf_pkg::CAP_W-1:0]     capacity_ff;
   logic [bbsf_pkg::ADDR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bbsf_pkg::ADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bbsf_pkg::COUNT_W-1:0]   held_ff, held_in;
   logic [bbsf_pkg::TOTAL_W-1:0]   pushed_ff, pushed_in;
   logic [bbsf_pkg::TOTAL_W-1:0]   popped_ff, popped_in;
   logic                           closed_ff, closed_in;
   logic                           error_ff, error_in;

   logic                           mem_we;
   logic [bbsf_pkg::WIDE_W-1:0]    cap_wide;
   logic [bbsf_pkg::WIDE_W-1:0]    cap_eff;
   logic [bbsf_pkg::WIDE_W-1:0]    held_wide;
   logic                           has_room;
   logic [bbsf_pkg::COUNT_W-1:0]   pop_amt;

   // Capacity beyond the store depth saturates at the depth.
   assign cap_wide  = bbsf_pkg::WIDE_W'(capacity_ff);
   assign cap_eff   = (cap_wide > bbsf_pkg::WIDE_W'(bbsf_pkg::DEPTH)) ?
                      bbsf_pkg::WIDE_W'(bbsf_pkg::DEPTH) : cap_wide;
   assign held_wide = bbsf_pkg::WIDE_W'(held_ff);
   assign has_room  = (held_wide < cap_eff);

   // A pop removes at most the bytes held.
   assign pop_amt = (bbsf_pkg::CMP_W'(len_ff) > bbsf_pkg::CMP_W'(held_ff)) ?
                    held_ff : bbsf_pkg::COUNT_W'(len_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      held_in   = held_ff;
      pushed_in = pushed_ff;
      popped_in = popped_ff;
      closed_in = closed_ff;
      error_in  = error_ff;
      mem_we    = 1'b0;
      if (cmd.exec) begin
         unique case (type_ff)
            bbsf_pkg::REQ_PUSH: begin
               priority if (error_ff) begin
                  error_in = 1'b1;
               end else if (closed_ff) begin
                  error_in = 1'b1;
               end else if (has_room) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_ff + bbsf_pkg::ADDR_W'(1);
                  held_in   = held_ff + bbsf_pkg::COUNT_W'(1);
                  pushed_in = pushed_ff + bbsf_pkg::TOTAL_W'(1);
               end else begin
                  mem_we = 1'b0;
               end
            end
            bbsf_pkg::REQ_POP: begin
               rd_ptr_in = rd_ptr_ff + bbsf_pkg::ADDR_W'(pop_amt);
               held_in   = held_ff - pop_amt;
               popped_in = popped_ff + bbsf_pkg::TOTAL_W'(pop_amt);
            end
            bbsf_pkg::REQ_CLOSE: closed_in = 1'b1;
            default: closed_in = closed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bbsf_pkg::CAPACITY_RESET;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         held_ff     <= '0;
         pushed_ff   <= '0;
         popped_ff   <= '0;
         closed_ff   <= 1'b0;
         error_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         held_ff   <= held_in;
         pushed_ff <= pushed_in;
         popped_ff <= popped_in;
         closed_ff <= closed_in;
         error_ff  <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         byte_ff <= req_push_byte;
         len_ff  <= req_pop_len;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= byte_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rsp_front_valid    = (held_ff != '0);
   assign rsp_front_byte     = rsp_front_valid ? rd_data_ff : 8'd0;
   assign rsp_buffered_count = 11'(held_ff);
   assign rsp_free_count     = (held_wide >= cap_eff) ? 11'd0 : 11'(cap_eff - held_wide);
   assign rsp_pushed_count   = pushed_ff;
   assign rsp_popped_count   = popped_ff;
   assign rsp_closed_flag    = closed_ff;
   assign rsp_finished_flag  = closed_ff && (held_ff == '0);
   assign rsp_error_flag     = error_ff;

endmodule

### hw/rtl/bounded_byte_stream_fifo_core.sv
// Top level of the bounded byte stream FIFO core.
// Instantiates bbsf_ctrl and bbsf_datapath; uses bbsf_pkg.
//
// Usage:
// The request channel (req_valid/req_ready) carries one word per request:
// req_type selects push of req_push_byte, pop of up to req_pop_len bytes,
// or close of the writer side. Every request yields exactly one response
// word on rsp_valid/rsp_ready with the front byte, buffered and free counts,
// the 32-bit pushed and popped totals, and the closed, finished and error
// flags as they stand after the request.
// A request is captured at its accepting edge; the EXEC state then updates pointers,
// totals and the store, the READ state registers the front byte, and the
// response word is offered in the RESP state until the receiver takes it.
// Each request passes through the four controller states IDLE, EXEC, READ
// and RESP, so a new request is taken only after the last response is taken.
// The core handles one request at a time: req_ready stays low from
// acceptance until the response word is taken, so a stalled receiver holds
// the response and back-pressures the sender.
// Reset clears pointers, totals and flags and sets the capacity to 1024;
// the store contents are not cleared. Write csr_write_data only while idle.
module bounded_byte_stream_fifo_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [bbsf_pkg::CAP_W-1:0]     csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [7:0]                     req_push_byte,
   input  logic [bbsf_pkg::LEN_W-1:0]     req_pop_len,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_front_byte,
   output logic                           rsp_front_valid,
   output logic [10:0]                    rsp_buffered_count,
   output logic [10:0]                    rsp_free_count,
   output logic [bbsf_pkg::TOTAL_W-1:0]   rsp_pushed_count,
   output logic [bbsf_pkg::TOTAL_W-1:0]   rsp_popped_count,
   output logic                           rsp_closed_flag,
   output logic                           rsp_finished_flag,
   output logic                           rsp_error_flag
);

   bbsf_pkg::cmd_type cmd;

   bbsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bbsf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_type           (req_type),
      .req_push_byte      (req_push_byte),
      .req_pop_len        (req_pop_len),
      .rsp_front_byte     (rsp_front_byte),
      .rsp_front_valid    (rsp_front_valid),
      .rsp_buffered_count (rsp_buffered_count),
      .rsp_free_count     (rsp_free_count),
      .rsp_pushed_count   (rsp_pushed_count),
      .rsp_popped_count   (rsp_popped_count),
      .rsp_closed_flag    (rsp_closed_flag),
      .rsp_finished_flag  (rsp_finished_flag),
      .rsp_error_flag     (rsp_error_flag)
   );

endmodule

### hw/rtl/bbsf_checker.sv
// Port-level checker for the bounded byte stream FIFO core.
// Bound to bounded_byte_stream_fifo_core; uses bbsf_pkg.
module bbsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_front_valid,
   input logic [10:0] rsp_buffered_count,
   input logic [10:0] rsp_free_count,
   input logic        rsp_closed_flag,
   input logic        rsp_finished_flag
);

   // A response word waits until the receiver takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_front_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_front_valid == (rsp_buffered_count != 11'd0))
      else $error("front valid disagrees with buffered count");

   a_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_finished_flag == (rsp_closed_flag && rsp_buffered_count == 11'd0))
      else $error("finished flag inconsistent");

   // Buffered plus free never exceeds the store depth.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_buffered_count) + 32'(rsp_free_count)) <= 32'(bbsf_pkg::DEPTH))
      else $error("occupancy exceeds store depth");

endmodule

bind bounded_byte_stream_fifo_core bbsf_checker u_bbsf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_front_valid    (rsp_front_valid),
   .rsp_buffered_count (rsp_buffered_count),
   .rsp_free_count     (rsp_free_count),
   .rsp_closed_flag    (rsp_closed_flag),
   .rsp_finished_flag  (rsp_finished_flag)
);

### tb/tb_bounded_byte_stream_fifo_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_byte_stream_fifo_core: response words are predicted
// by a behavioral byte ring and every response word is compared field by field.
// Depends on bbsf_pkg and the core RTL only.
module tb_bounded_byte_stream_fifo_core;

   localparam logic [1:0] REQ_NOOP      = 2'd3;
   localparam int         QUIET_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         FILL_WORDS    = 260;

   typedef struct {
      logic [7:0]  front_byte;
      logic        front_valid;
      logic [10:0] buffered;
      logic [10:0] free;
      logic [31:0] pushed;
      logic [31:0] popped;
      logic        closed;
      logic        finished;
      logic        error;
   } fifo_status_type;

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [bbsf_pkg::CAP_W-1:0]    csr_write_data   = '0;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_type         = bbsf_pkg::REQ_PUSH;
   logic [7:0]                    req_push_byte    = 8'h00;
   logic [bbsf_pkg::LEN_W-1:0]    req_pop_len      = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic [7:0]                    rsp_front_byte;
   logic                          rsp_front_valid;
   logic [10:0]                   rsp_buffered_count;
   logic [10:0]                   rsp_free_count;
   logic [bbsf_pkg::TOTAL_W-1:0]  rsp_pushed_count;
   logic [bbsf_pkg::TOTAL_W-1:0]  rsp_popped_count;
   logic                          rsp_closed_flag;
   logic                          rsp_finished_flag;
   logic                          rsp_error_flag;

   // Behavioral copy of the FIFO state, advanced as each request word is accepted.
   logic [7:0]                    ring_bytes [bbsf_pkg::DEPTH];
   int                            wr_index         = 0;
   int                            rd_index         = 0;
   logic [31:0]                   bytes_in         = '0;
   logic [31:0]                   bytes_out        = '0;
   logic                          writer_closed    = 1'b0;
   logic                          push_error       = 1'b0;
   logic [bbsf_pkg::CAP_W-1:0]    capacity_setting = bbsf_pkg::CAPACITY_RESET;

   fifo_status_type               pending_status [$];
   int                            failures         = 0;
   int                            quiet_cycles     = 0;
   bit                            req_gaps_on      = 1'b1;
   bit                            rsp_gaps_on      = 1'b1;
   int                            sink_hold_cycles = 0;

   bounded_byte_stream_fifo_core uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_push_byte      (req_push_byte),
      .req_pop_len        (req_pop_len),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_front_byte     (rsp_front_byte),
      .rsp_front_valid    (rsp_front_valid),
      .rsp_buffered_count (rsp_buffered_count),
      .rsp_free_count     (rsp_free_count),
      .rsp_pushed_count   (rsp_pushed_count),
      .rsp_popped_count   (rsp_popped_count),
      .rsp_closed_flag    (rsp_closed_flag),
      .rsp_finished_flag  (rsp_finished_flag),
      .rsp_error_flag     (rsp_error_flag)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Room left under the capacity, which saturates at the store depth.
   function automatic logic [31:0] space_left();
      logic [31:0] limit;
      logic [31:0] held;
      limit = (capacity_setting > bbsf_pkg::DEPTH) ? bbsf_pkg::DEPTH : capacity_setting;
      held  = bytes_in - bytes_out;
      return (held >= limit) ? 32'd0 : limit - held;
   endfunction

   function automatic fifo_status_type predict_status(input logic [1:0] kind,
         input logic [7:0] data, input logic [15:0] len);
      fifo_status_type s;
      logic [31:0]     held;
      logic [31:0]     taken;
      if (kind == bbsf_pkg::REQ_PUSH) begin
         if (!push_error) begin
            if (writer_closed) begin
               push_error = 1'b1;
            end else if (space_left() > 0) begin
               ring_bytes[wr_index] = data;
               wr_index = (wr_index + 1) % bbsf_pkg::DEPTH;
               bytes_in = bytes_in + 1;
            end
         end
      end else if (kind == bbsf_pkg::REQ_POP) begin
         held  = bytes_in - bytes_out;
         taken = (32'(len) > held) ? held : 32'(len);
         rd_index  = (rd_index + taken) % bbsf_pkg::DEPTH;
         bytes_out = bytes_out + taken;
      end else if (kind == bbsf_pkg::REQ_CLOSE) begin
         writer_closed = 1'b1;
      end
      held          = bytes_in - bytes_out;
      s.front_valid = (held != 0);
      s.front_byte  = (held != 0) ? ring_bytes[rd_index] : 8'h00;
      s.buffered    = held[10:0];
      s.free        = 11'(space_left());
      s.pushed      = bytes_in;
      s.popped      = bytes_out;
      s.closed      = writer_closed;
      s.finished    = writer_closed && (held == 0);
      s.error       = push_error;
      return s;
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [7:0] data,
         input logic [15:0] len);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_push_byte <= data;
      req_pop_len   <= len;
      do @(posedge clock); while (!req_ready);
      pending_status.insert(pending_status.size(), predict_status(kind, data, len));
   endtask

   function automatic logic [15:0] draw_pop_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 16'($urandom_range(0, 4));
      else if (pick < 85)
         return 16'($urandom_range(0, 64));
      else if (pick < 95)
         return 16'($urandom_range(0, 2047));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_random_request(input bit allow_close);
      int         pick;
      logic [1:0] kind;
      pick = $urandom_range(0, 99);
      if (allow_close)
         kind = 2'($urandom_range(0, 3));
      else if (pick < 72)
         kind = bbsf_pkg::REQ_PUSH;
      else if (pick < 94)
         kind = bbsf_pkg::REQ_POP;
      else
         kind = REQ_NOOP;
      send_request(kind, 8'($urandom_range(0, 255)), draw_pop_len());
   endtask

   // Drops valid and waits until every response word is back and the core is quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [bbsf_pkg::CAP_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_setting = value;
   endtask

   task automatic test_empty_fifo();
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'h0000);
      send_request(REQ_NOOP, 8'hFF, 16'hFFFF);
      send_request(bbsf_pkg::REQ_POP, 8'h5A, 16'hFFFF);
   endtask

   task automatic test_capacity_edges();
      write_capacity(11'd0);
      send_request(bbsf_pkg::REQ_PUSH, 8'hFF, 16'h0000);
      write_capacity(11'd2);
      send_request(bbsf_pkg::REQ_PUSH, 8'h00, 16'hFFFF);
      send_request(bbsf_pkg::REQ_PUSH, 8'hFF, 16'h0000);
      send_request(bbsf_pkg::REQ_PUSH, 8'h5A, 16'h0000);
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'h0001);
      send_request(bbsf_pkg::REQ_PUSH, 8'hA5, 16'h0000);
      // All ones is above the store depth, so the free count is taken against 1024.
      write_capacity(11'h7FF);
      send_request(bbsf_pkg::REQ_PUSH, 8'h81, 16'h0000);
      // Three bytes held under a capacity of one: nothing fits until they drain.
      write_capacity(11'd1);
      send_request(bbsf_pkg::REQ_PUSH, 8'h7E, 16'h0000);
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'h0002);
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'hFFFF);
      write_capacity(bbsf_pkg::CAPACITY_RESET);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         unique case (phase)
            0: begin
               write_capacity(bbsf_pkg::CAPACITY_RESET);
               req_gaps_on = 1'b1;
               rsp_gaps_on = 1'b1;
            end
            1: begin
               write_capacity(11'($urandom_range(1, 8)));
               req_gaps_on = 1'b0;
               rsp_gaps_on = 1'b1;
            end
            2: begin
               write_capacity(11'h7FF);
               req_gaps_on = 1'b1;
               rsp_gaps_on = 1'b0;
            end
            3: begin
               write_capacity(11'($urandom_range(0, 2047)));
               req_gaps_on = 1'b1;
               rsp_gaps_on = 1'b1;
            end
            default: begin
               write_capacity(11'($urandom_range(16, 64)));
               req_gaps_on = 1'b0;
               rsp_gaps_on = 1'b0;
            end
         endcase
         repeat (80) send_random_request(1'b0);
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Pushes a long run with no gaps under the full capacity, then drains it
   // with short pops so the read side walks far through the store.
   task automatic test_deep_fill();
      write_capacity(11'(bbsf_pkg::DEPTH));
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_request(bbsf_pkg::REQ_POP, 8'($urandom_range(0, 255)), 16'hFFFF);
      repeat (FILL_WORDS)
         send_request(bbsf_pkg::REQ_PUSH, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
      while (bytes_in != bytes_out)
         send_request(bbsf_pkg::REQ_POP, 8'($urandom_range(0, 255)),
                      16'($urandom_range(1, 64)));
      repeat (20)
         send_request(bbsf_pkg::REQ_PUSH, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      sink_hold_cycles = HOLD_CYCLES;
      req_gaps_on = 1'b0;
      repeat (16) send_random_request(1'b0);
      req_gaps_on = 1'b1;
   endtask

   // The writer stays closed for the rest of the run once closed, so this comes last.
   task automatic test_close_and_error();
      send_request(bbsf_pkg::REQ_PUSH, 8'hC3, 16'h0000);
      send_request(bbsf_pkg::REQ_CLOSE, 8'h00, 16'h0000);
      send_request(bbsf_pkg::REQ_CLOSE, 8'hFF, 16'hFFFF);
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'h0001);
      send_request(bbsf_pkg::REQ_PUSH, 8'hEE, 16'h0000);
      send_request(bbsf_pkg::REQ_PUSH, 8'h11, 16'h0000);
      send_request(REQ_NOOP, 8'h00, 16'h0000);
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'hFFFF);
      send_request(bbsf_pkg::REQ_POP, 8'h00, 16'h0000);
      repeat (40) send_random_request(1'b1);
   endtask

   initial begin : response_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
            stall = 0;
         end else begin
            stall = rsp_gaps_on ? $urandom_range(0, 15) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : response_check
      fifo_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $error("response word arrived with no request outstanding");
            failures++;
         end else begin
            want = pending_status[0];
            pending_status.delete(0);
            check_field("front_byte", want.front_byte, rsp_front_byte);
            check_field("front_valid", want.front_valid, rsp_front_valid);
            check_field("buffered_count", want.buffered, rsp_buffered_count);
            check_field("free_count", want.free, rsp_free_count);
            check_field("pushed_count", want.pushed, rsp_pushed_count);
            check_field("popped_count", want.popped, rsp_popped_count);
            check_field("closed_flag", want.closed, rsp_closed_flag);
            check_field("finished_flag", want.finished, rsp_finished_flag);
            check_field("error_flag", want.error, rsp_error_flag);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_fifo();
      test_capacity_edges();
      test_random_traffic();
      test_deep_fill();
      test_output_backpressure();
      test_close_and_error();
      wait_idle();
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
